// ===== hw/rtl/hrbb_pkg.sv =====
`timescale 1ns / 1ps

package hrbb_pkg;

  // Field and register widths.
  localparam int COORD_BITS_DEF = 12;
  localparam int RECT_W         = 12;
  localparam int OUT_W          = 16;
  localparam int COEF_W         = 32;
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int CORNERS        = 4;

  // The quotient is num * 2^12 * 2^16 / den, so the numerator moves up by 28 bits.
  localparam int FRAC_SHIFT      = 28;
  // Quotient bits below the saturation point of 2^40 in Q.16.
  localparam int QUOT_BITS       = 56;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = QUOT_BITS / STEPS_PER_STAGE;

  // Signed Q.16 corner values and their differences.
  localparam int VAL_W  = QUOT_BITS + 2;
  localparam int DIFF_W = VAL_W + 1;
  localparam logic signed [VAL_W-1:0] START_MIN = VAL_W'(64'sd999999 * 64'sd65536);

  // Pipeline depths of the three parts.
  localparam int PROJ_LAT   = 3;
  localparam int DIV_LAT    = DIV_STAGES + 2;
  localparam int REDUCE_LAT = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_H00_H01 = 3'd0,
    CFG_H02_H10 = 3'd1,
    CFG_H11_H12 = 3'd2,
    CFG_H20_H21 = 3'd3,
    CFG_H22     = 3'd4
  } cfg_idx_t;

  // Unpacked view of the homography.
  typedef struct packed {
    logic signed [COEF_W-1:0] h00;
    logic signed [COEF_W-1:0] h01;
    logic signed [COEF_W-1:0] h02;
    logic signed [COEF_W-1:0] h10;
    logic signed [COEF_W-1:0] h11;
    logic signed [COEF_W-1:0] h12;
    logic signed [COEF_W-1:0] h20;
    logic signed [COEF_W-1:0] h21;
    logic signed [COEF_W-1:0] h22;
  } coef_t;

endpackage

// ===== hw/rtl/hrbb_proj.sv =====
`timescale 1ns / 1ps

// One corner lane: corner point, products, then the two numerators and the denominator.
module hrbb_proj
  import hrbb_pkg::*;
#(
  parameter int PT_W = COORD_BITS_DEF + 1,
  parameter bit DX   = 1'b0,
  parameter bit DY   = 1'b0
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [PT_W-1:0]        rect_x,
  input  logic [PT_W-1:0]        rect_y,
  input  logic [PT_W-1:0]        rect_width,
  input  logic [PT_W-1:0]        rect_height,
  input  coef_t                  coef,
  output logic signed [PT_W+33:0] num_x,
  output logic signed [PT_W+33:0] num_y,
  output logic signed [PT_W+33:0] den
);

  localparam int PROD_W = PT_W + 33;
  localparam int SUM_W  = PT_W + 34;

  logic [PT_W-1:0]          px_r, py_r;
  logic signed [PROD_W-1:0] pxx_r, pxy_r, pyx_r, pyy_r, pdx_r, pdy_r;
  logic signed [COEF_W-1:0] h02_r, h12_r, h22_r;
  logic signed [SUM_W-1:0]  num_x_r, num_y_r, den_r;

  // Stage 1: the corner point.
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= DX ? PT_W'(rect_x + rect_width) : rect_x;
      py_r <= DY ? PT_W'(rect_y + rect_height) : rect_y;
    end
  end

  // Stage 2: six products of the point with the first two columns.
  always_ff @(posedge clk) begin
    if (en) begin
      pxx_r <= $signed({1'b0, px_r}) * coef.h00;
      pxy_r <= $signed({1'b0, py_r}) * coef.h01;
      pyx_r <= $signed({1'b0, px_r}) * coef.h10;
      pyy_r <= $signed({1'b0, py_r}) * coef.h11;
      pdx_r <= $signed({1'b0, px_r}) * coef.h20;
      pdy_r <= $signed({1'b0, py_r}) * coef.h21;
      h02_r <= coef.h02;
      h12_r <= coef.h12;
      h22_r <= coef.h22;
    end
  end

  // Stage 3: add the offsets.
  always_ff @(posedge clk) begin
    if (en) begin
      num_x_r <= SUM_W'(pxx_r) + SUM_W'(pxy_r) + SUM_W'(h02_r);
      num_y_r <= SUM_W'(pyx_r) + SUM_W'(pyy_r) + SUM_W'(h12_r);
      den_r   <= SUM_W'(pdx_r) + SUM_W'(pdy_r) + SUM_W'(h22_r);
    end
  end

  assign num_x = num_x_r;
  assign num_y = num_y_r;
  assign den   = den_r;

endmodule

// ===== hw/rtl/hrbb_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider: signed Q.16 quotient of num * 2^12 / den,
// truncated toward zero, with the integer part saturated at 2^40.
module hrbb_div
  import hrbb_pkg::*;
#(
  parameter int MAG_W = COORD_BITS_DEF + 34
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [MAG_W:0]   num,
  input  logic signed [MAG_W:0]   den,
  output logic signed [VAL_W-1:0] quot,
  output logic                    zero
);

  localparam int LOW_PAD = QUOT_BITS - FRAC_SHIFT;

  logic [MAG_W:0]         num_abs, den_abs;
  logic [MAG_W-1:0]       mag_n, mag_d, hi_n;

  logic [MAG_W-1:0]       rem_r  [DIV_STAGES+1];
  logic [QUOT_BITS-1:0]   sr_r   [DIV_STAGES+1];
  logic [MAG_W-1:0]       d_r    [DIV_STAGES+1];
  logic [DIV_STAGES:0]    neg_r, sat_r, zero_r;

  logic [QUOT_BITS:0]     qmag;
  logic signed [VAL_W-1:0] quot_r;
  logic                   zero_out_r;

  // Magnitudes and the saturation check.
  always_comb begin
    num_abs = num[MAG_W] ? -num : num;
    den_abs = den[MAG_W] ? -den : den;
    mag_n   = num_abs[MAG_W-1:0];
    mag_d   = den_abs[MAG_W-1:0];
    hi_n    = mag_n >> FRAC_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= hi_n;
      sr_r[0]   <= {mag_n[FRAC_SHIFT-1:0], LOW_PAD'(0)};
      d_r[0]    <= mag_d;
      neg_r[0]  <= num[MAG_W] ^ den[MAG_W];
      sat_r[0]  <= hi_n >= mag_d;
      zero_r[0] <= mag_d == '0;
    end
  end

  // Each stage settles a few quotient bits. The shift register feeds the
  // low numerator bits out of its top and takes quotient bits in at the bottom.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [MAG_W-1:0]     rem_nxt;
    logic [QUOT_BITS-1:0] sr_nxt;
    logic [MAG_W:0]       trial;

    always_comb begin
      rem_nxt = rem_r[s];
      sr_nxt  = sr_r[s];
      trial   = '0;
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
        trial = {rem_nxt, sr_nxt[QUOT_BITS-1]};
        if (trial >= {1'b0, d_r[s]}) begin
          rem_nxt = MAG_W'(trial - {1'b0, d_r[s]});
          sr_nxt  = {sr_nxt[QUOT_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = trial[MAG_W-1:0];
          sr_nxt  = {sr_nxt[QUOT_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= rem_nxt;
        sr_r[s+1]   <= sr_nxt;
        d_r[s+1]    <= d_r[s];
        neg_r[s+1]  <= neg_r[s];
        sat_r[s+1]  <= sat_r[s];
        zero_r[s+1] <= zero_r[s];
      end
    end
  end

  // Apply saturation and sign.
  always_comb begin
    qmag = sat_r[DIV_STAGES] ? {1'b1, QUOT_BITS'(0)} : {1'b0, sr_r[DIV_STAGES]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r     <= neg_r[DIV_STAGES] ? -$signed(VAL_W'(qmag)) : $signed(VAL_W'(qmag));
      zero_out_r <= zero_r[DIV_STAGES];
    end
  end

  assign quot = quot_r;
  assign zero = zero_out_r;

endmodule

// ===== hw/rtl/hrbb_reduce.sv =====
`timescale 1ns / 1ps

// Bounding box of the mapped corners, then truncation and saturation.
module hrbb_reduce
  import hrbb_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [VAL_W-1:0] qx [CORNERS],
  input  logic signed [VAL_W-1:0] qy [CORNERS],
  input  logic [CORNERS-1:0]      zero,
  output logic [OUT_W-1:0]        out_x,
  output logic [OUT_W-1:0]        out_y,
  output logic [OUT_W-1:0]        out_width,
  output logic [OUT_W-1:0]        out_height,
  output logic                    divide_fault
);

  localparam logic signed [DIFF_W-1:0] ROUND_UP = DIFF_W'(65535);
  localparam logic signed [DIFF_W-1:0] S16_MIN  = -DIFF_W'(32768);
  localparam logic signed [DIFF_W-1:0] S16_MAX  = DIFF_W'(32767);
  localparam logic signed [DIFF_W-1:0] U16_MAX  = DIFF_W'(65535);

  function automatic logic signed [VAL_W-1:0] vmin(logic signed [VAL_W-1:0] a,
                                                   logic signed [VAL_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [VAL_W-1:0] vmax(logic signed [VAL_W-1:0] a,
                                                   logic signed [VAL_W-1:0] b);
    return (b > a) ? b : a;
  endfunction

  // Truncate a Q.16 value toward zero.
  function automatic logic signed [DIFF_W-1:0] trunc_q16(logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? ((v + ROUND_UP) >>> 16) : (v >>> 16);
  endfunction

  logic signed [VAL_W-1:0]  mnx_a_r [2], mny_a_r [2], mxx_a_r [2], mxy_a_r [2];
  logic                     fault_a_r, fault_b_r, fault_c_r, fault_d_r;
  logic signed [VAL_W-1:0]  mnx_b_r, mny_b_r, mxx_b_r, mxy_b_r;
  logic signed [VAL_W-1:0]  mnx_c_r, mny_c_r;
  logic signed [DIFF_W-1:0] dx_c_r, dy_c_r;
  logic signed [DIFF_W-1:0] tx, ty, tw, th;
  logic [OUT_W-1:0]         out_x_r, out_y_r, out_w_r, out_h_r;

  // Stage A: pairs of corners; a faulty corner stands in as the start value.
  for (genvar p = 0; p < 2; p++) begin : g_pair
    always_ff @(posedge clk) begin
      if (en) begin
        mnx_a_r[p] <= vmin(zero[2*p] ? START_MIN : qx[2*p],
                           zero[2*p+1] ? START_MIN : qx[2*p+1]);
        mny_a_r[p] <= vmin(zero[2*p] ? START_MIN : qy[2*p],
                           zero[2*p+1] ? START_MIN : qy[2*p+1]);
        mxx_a_r[p] <= vmax(zero[2*p] ? '0 : qx[2*p], zero[2*p+1] ? '0 : qx[2*p+1]);
        mxy_a_r[p] <= vmax(zero[2*p] ? '0 : qy[2*p], zero[2*p+1] ? '0 : qy[2*p+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fault_a_r <= |zero;
    end
  end

  // Stage B: whole box, with the start values folded in.
  always_ff @(posedge clk) begin
    if (en) begin
      mnx_b_r   <= vmin(vmin(mnx_a_r[0], mnx_a_r[1]), START_MIN);
      mny_b_r   <= vmin(vmin(mny_a_r[0], mny_a_r[1]), START_MIN);
      mxx_b_r   <= vmax(vmax(mxx_a_r[0], mxx_a_r[1]), '0);
      mxy_b_r   <= vmax(vmax(mxy_a_r[0], mxy_a_r[1]), '0);
      fault_b_r <= fault_a_r;
    end
  end

  // Stage C: extents.
  always_ff @(posedge clk) begin
    if (en) begin
      dx_c_r    <= DIFF_W'(mxx_b_r) - DIFF_W'(mnx_b_r);
      dy_c_r    <= DIFF_W'(mxy_b_r) - DIFF_W'(mny_b_r);
      mnx_c_r   <= mnx_b_r;
      mny_c_r   <= mny_b_r;
      fault_c_r <= fault_b_r;
    end
  end

  // Stage D: truncate to integers and saturate to the output ranges.
  always_comb begin
    tx = trunc_q16(DIFF_W'(mnx_c_r));
    ty = trunc_q16(DIFF_W'(mny_c_r));
    tw = trunc_q16(dx_c_r);
    th = trunc_q16(dy_c_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r   <= (tx < S16_MIN) ? 16'h8000 : (tx > S16_MAX) ? 16'h7FFF : tx[OUT_W-1:0];
      out_y_r   <= (ty < S16_MIN) ? 16'h8000 : (ty > S16_MAX) ? 16'h7FFF : ty[OUT_W-1:0];
      out_w_r   <= tw[DIFF_W-1] ? 16'h0000 : (tw > U16_MAX) ? 16'hFFFF : tw[OUT_W-1:0];
      out_h_r   <= th[DIFF_W-1] ? 16'h0000 : (th > U16_MAX) ? 16'hFFFF : th[OUT_W-1:0];
      fault_d_r <= fault_c_r;
    end
  end

  assign out_x        = out_x_r;
  assign out_y        = out_y_r;
  assign out_width    = out_w_r;
  assign out_height   = out_h_r;
  assign divide_fault = fault_d_r;

endmodule

// ===== hw/rtl/homography_rect_bounding_box_unit.sv =====
// Pipeline from input transfer to result: 3 projection stages, 30 divider stages (an input
// register, 28 stages at two quotient bits each and an output register), then 4 bounding box
// stages.
// Throughput: one rectangle per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n low, synchronous) clears all valid bits and loads the identity homography.
`timescale 1ns / 1ps

module homography_rect_bounding_box_unit
  import hrbb_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // rect_x[11:0], rect_y[23:12], rect_width[35:24], rect_height[47:36]
  input  logic [47:0]          in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // out_x[15:0], out_y[31:16], out_width[47:32], out_height[63:48],
  // divide_fault[64], zero fill [71:65]
  output logic [71:0]          out_tdata,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int PT_W  = COORD_BITS + 1;
  localparam int MAG_W = PT_W + 33;
  localparam int SUM_W = PT_W + 34;
  localparam int LAT   = PROJ_LAT + DIV_LAT + REDUCE_LAT;
  localparam logic [RECT_W-1:0] CMASK =
    (COORD_BITS >= RECT_W) ? {RECT_W{1'b1}} : RECT_W'((64'd1 << COORD_BITS) - 64'd1);

  logic [CFG_W-1:0]  coef_h00_h01_r, coef_h02_h10_r, coef_h11_h12_r, coef_h20_h21_r;
  logic [COEF_W-1:0] coef_h22_r;
  coef_t             coef;

  logic              en;
  logic [LAT-1:0]    vld_r;
  logic [PT_W-1:0]   rx, ry, rw, rh;

  logic signed [SUM_W-1:0] num_x [CORNERS];
  logic signed [SUM_W-1:0] num_y [CORNERS];
  logic signed [SUM_W-1:0] den   [CORNERS];
  logic signed [VAL_W-1:0] qx    [CORNERS];
  logic signed [VAL_W-1:0] qy    [CORNERS];
  logic [CORNERS-1:0]      zero;

  logic [OUT_W-1:0] res_x, res_y, res_w, res_h;
  logic             res_fault;

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_h00_h01_r <= CFG_W'(65536);
      coef_h02_h10_r <= '0;
      coef_h11_h12_r <= CFG_W'(65536);
      coef_h20_h21_r <= '0;
      coef_h22_r     <= COEF_W'(268435456);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_H00_H01: coef_h00_h01_r <= cfg_wdata;
        CFG_H02_H10: coef_h02_h10_r <= cfg_wdata;
        CFG_H11_H12: coef_h11_h12_r <= cfg_wdata;
        CFG_H20_H21: coef_h20_h21_r <= cfg_wdata;
        CFG_H22:     coef_h22_r     <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.h00 = coef_h00_h01_r[COEF_W-1:0];
    coef.h01 = coef_h00_h01_r[CFG_W-1:COEF_W];
    coef.h02 = coef_h02_h10_r[COEF_W-1:0];
    coef.h10 = coef_h02_h10_r[CFG_W-1:COEF_W];
    coef.h11 = coef_h11_h12_r[COEF_W-1:0];
    coef.h12 = coef_h11_h12_r[CFG_W-1:COEF_W];
    coef.h20 = coef_h20_h21_r[COEF_W-1:0];
    coef.h21 = coef_h20_h21_r[CFG_W-1:COEF_W];
    coef.h22 = coef_h22_r;
  end

  // The pipeline advances unless a finished result is still waiting.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Only the low COORD_BITS bits of each field take part.
  always_comb begin
    rx = PT_W'(in_tdata[11:0] & CMASK);
    ry = PT_W'(in_tdata[23:12] & CMASK);
    rw = PT_W'(in_tdata[35:24] & CMASK);
    rh = PT_W'(in_tdata[47:36] & CMASK);
  end

  // One lane per corner: projection and two dividers.
  for (genvar c = 0; c < CORNERS; c++) begin : g_corner
    hrbb_proj #(
      .PT_W (PT_W),
      .DX   (c[0]),
      .DY   (c[1])
    ) u_proj (
      .clk         (clk),
      .en          (en),
      .rect_x      (rx),
      .rect_y      (ry),
      .rect_width  (rw),
      .rect_height (rh),
      .coef        (coef),
      .num_x       (num_x[c]),
      .num_y       (num_y[c]),
      .den         (den[c])
    );

    hrbb_div #(.MAG_W(MAG_W)) u_div_x (
      .clk  (clk),
      .en   (en),
      .num  (num_x[c]),
      .den  (den[c]),
      .quot (qx[c]),
      .zero (zero[c])
    );

    hrbb_div #(.MAG_W(MAG_W)) u_div_y (
      .clk  (clk),
      .en   (en),
      .num  (num_y[c]),
      .den  (den[c]),
      .quot (qy[c]),
      .zero ()
    );
  end

  hrbb_reduce u_reduce (
    .clk          (clk),
    .en           (en),
    .qx           (qx),
    .qy           (qy),
    .zero         (zero),
    .out_x        (res_x),
    .out_y        (res_y),
    .out_width    (res_w),
    .out_height   (res_h),
    .divide_fault (res_fault)
  );

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {7'b0, res_fault, res_h, res_w, res_y, res_x};

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hrbb_pkg::*;

  localparam int PIPE_DEPTH = 37;
  localparam int STALL_LIMIT = 20000;
  // An index past the end of the register list.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct {
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [15:0]        box_w;
    logic [15:0]        box_h;
    logic               fault;
  } box_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Local copy of the homography registers.
  logic [63:0] reg_r0, reg_r1, reg_r2, reg_r3;
  logic [31:0] reg_h22;

  box_t expected_boxes[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int idle_cycles = 0;

  homography_rect_bounding_box_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Signed Q.16 quotient of num * 2^12 / den, truncated toward zero.
  function automatic longint project_q16(longint num, longint den);
    logic [127:0] mag_n, mag_d, quo;
    bit neg;
    neg = (num < 0) != (den < 0);
    mag_n = 128'(num < 0 ? -num : num) << 28;
    mag_d = 128'(den < 0 ? -den : den);
    quo = mag_n / mag_d;
    if ((quo >> 16) >= (128'd1 << 40)) quo = 128'd1 << 56;
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic longint trunc_clamp(longint v, longint lo, longint hi);
    longint t;
    t = v < 0 ? -((-v) >>> 16) : (v >>> 16);
    if (t < lo) return lo;
    if (t > hi) return hi;
    return t;
  endfunction

  // Bounding box of the four mapped corners.
  function automatic box_t map_rect(logic [47:0] rect);
    longint x0, y0, wd, ht, px, py, den, mx, my;
    longint minx, miny, maxx, maxy;
    longint h00, h01, h02, h10, h11, h12, h20, h21, h22;
    box_t b;
    x0 = rect[11:0]; y0 = rect[23:12]; wd = rect[35:24]; ht = rect[47:36];
    h00 = signed'(reg_r0[31:0]); h01 = signed'(reg_r0[63:32]);
    h02 = signed'(reg_r1[31:0]); h10 = signed'(reg_r1[63:32]);
    h11 = signed'(reg_r2[31:0]); h12 = signed'(reg_r2[63:32]);
    h20 = signed'(reg_r3[31:0]); h21 = signed'(reg_r3[63:32]);
    h22 = signed'(reg_h22);
    minx = 64'sd999999 * 65536; miny = minx; maxx = 0; maxy = 0;
    b.fault = 1'b0;
    for (int i = 0; i < 4; i++) begin
      px = x0 + (i[0] ? wd : 0);
      py = y0 + (i[1] ? ht : 0);
      den = px * h20 + py * h21 + h22;
      if (den == 0) begin
        b.fault = 1'b1;
        continue;
      end
      mx = project_q16(px * h00 + py * h01 + h02, den);
      my = project_q16(px * h10 + py * h11 + h12, den);
      if (mx < minx) minx = mx;
      if (my < miny) miny = my;
      if (mx > maxx) maxx = mx;
      if (my > maxy) maxy = my;
    end
    b.box_x = 16'(trunc_clamp(minx, -32768, 32767));
    b.box_y = 16'(trunc_clamp(miny, -32768, 32767));
    b.box_w = 16'(trunc_clamp(maxx - minx, 0, 65535));
    b.box_h = 16'(trunc_clamp(maxy - miny, 0, 65535));
    return b;
  endfunction

  // Registers change only once every accepted rectangle has come out.
  task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
    in_tvalid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_H00_H01: reg_r0 = value;
      CFG_H02_H10: reg_r1 = value;
      CFG_H11_H12: reg_r2 = value;
      CFG_H20_H21: reg_r3 = value;
      CFG_H22: reg_h22 = value[31:0];
      default: ;
    endcase
  endtask

  // Offers one rectangle, with random idle cycles before it.
  task automatic send_rect(logic [47:0] rect);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= rect;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_boxes.push_back(map_rect(rect));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  function automatic logic [47:0] pack_rect(int x, int y, int w, int h);
    return {12'(h), 12'(w), 12'(y), 12'(x)};
  endfunction

  function automatic logic [47:0] random_rect();
    int m;
    m = $urandom_range(3);
    if (m == 0) return 48'({$urandom, $urandom});
    return pack_rect($urandom_range(1023), $urandom_range(1023),
                     $urandom_range(255), $urandom_range(255));
  endfunction

  // Receiver ready with random stalls, or held low on request.
  always @(posedge clk) begin
    if (!rst_n || recv_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result check against the oldest expected box.
  always @(posedge clk) begin
    box_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_boxes.size() == 0) begin
        $error("result transfer with no expected box");
        errors++;
      end else begin
        e = expected_boxes.pop_front();
        if (out_tdata[15:0] !== e.box_x) begin
          $error("out_x exp %0d got %0d", e.box_x, $signed(out_tdata[15:0])); errors++;
        end
        if (out_tdata[31:16] !== e.box_y) begin
          $error("out_y exp %0d got %0d", e.box_y, $signed(out_tdata[31:16])); errors++;
        end
        if (out_tdata[47:32] !== e.box_w) begin
          $error("out_width exp %0d got %0d", e.box_w, out_tdata[47:32]); errors++;
        end
        if (out_tdata[63:48] !== e.box_h) begin
          $error("out_height exp %0d got %0d", e.box_h, out_tdata[63:48]); errors++;
        end
        if (out_tdata[64] !== e.fault) begin
          $error("divide_fault exp %0d got %0d", e.fault, out_tdata[64]); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("homography_rect_bounding_box_unit: mismatch");
      $finish;
    end
  end

  task automatic test_identity_extremes();
    send_rect(pack_rect(0, 0, 0, 0));
    send_rect(pack_rect(4095, 4095, 4095, 4095));
    send_rect(pack_rect(4095, 0, 0, 4095));
    send_rect(pack_rect(0, 4095, 4095, 0));
    send_rect(48'hFFFF_FFFF_FFFF);
    send_rect(pack_rect(100, 200, 30, 40));
    drain();
  endtask

  // Zero denominators: two corners, all corners; then a mirrored map with negative coordinates.
  task automatic test_faults();
    write_reg(CFG_H20_H21, {32'sd0, -32'sd268435456});
    write_reg(CFG_H22, 64'd268435456);
    send_rect(pack_rect(1, 5, 3, 2));
    send_rect(pack_rect(0, 0, 1, 1));
    write_reg(CFG_H20_H21, 64'd0);
    write_reg(CFG_H22, 64'd0);
    send_rect(pack_rect(10, 10, 10, 10));
    write_reg(CFG_H22, 64'd268435456);
    write_reg(CFG_H00_H01, {32'd0, -32'sd65536});
    write_reg(CFG_H11_H12, {32'd0, -32'sd65536});
    send_rect(pack_rect(50, 60, 70, 80));
    drain();
  endtask

  // Huge quotients and extreme coefficients.
  task automatic test_extremes();
    write_reg(CFG_H00_H01, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(CFG_H02_H10, {32'h8000_0000, 32'h7FFF_FFFF});
    write_reg(CFG_H11_H12, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    write_reg(CFG_H20_H21, 64'd0);
    write_reg(CFG_H22, 64'd1);
    send_rect(pack_rect(4095, 4095, 4095, 4095));
    send_rect(pack_rect(0, 0, 0, 0));
    write_reg(CFG_H22, 64'h8000_0000);
    send_rect(pack_rect(7, 9, 4095, 1));
    write_reg(CFG_H20_H21, {32'h8000_0000, 32'h7FFF_FFFF});
    write_reg(CFG_H22, 64'h7FFF_FFFF);
    send_rect(pack_rect(2048, 1024, 2047, 3071));
    write_reg(cfg_idx_t'(CFG_UNUSED_IDX), 64'hDEAD_BEEF);
    send_rect(pack_rect(3, 3, 3, 3));
    drain();
  endtask

  task automatic random_config();
    write_reg(CFG_H00_H01, {$urandom_range(1) ? $urandom : $urandom_range(8192),
                            32'(int'($urandom_range(262144)) - 131072)});
    write_reg(CFG_H02_H10, {32'(int'($urandom_range(131072)) - 65536), $urandom});
    write_reg(CFG_H11_H12, {$urandom, 32'(int'($urandom_range(262144)) - 131072)});
    write_reg(CFG_H20_H21, $urandom_range(1) ? 64'd0
              : {32'(int'($urandom_range(8192)) - 4096), 32'(int'($urandom_range(8192)) - 4096)});
    write_reg(CFG_H22, $urandom_range(3) == 0 ? 64'($urandom) : 64'd268435456);
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        drain();
        random_config();
      end
      send_rect(random_rect());
    end
    drain();
  endtask

  // Long receiver hold-off so the pipeline backs up into the input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 135; i++) send_rect(random_rect());
    join
    drain();
  endtask

  initial begin
    reg_r0 = 64'd65536; reg_r1 = 64'd0; reg_r2 = 64'd65536;
    reg_r3 = 64'd0; reg_h22 = 32'd268435456;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 29;
    recv_idle_pct = 83;
    test_identity_extremes();
    test_faults();
    test_extremes();
    test_random(300, 29, 83);
    test_random(300, 83, 29);
    test_random(300, 0, 0);
    test_backpressure();
    if (errors == 0) $display("homography_rect_bounding_box_unit: match");
    else $display("homography_rect_bounding_box_unit: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/hrbb_pkg.sv
hw/rtl/hrbb_proj.sv
hw/rtl/hrbb_div.sv
hw/rtl/hrbb_reduce.sv
hw/rtl/homography_rect_bounding_box_unit.sv
sim/testbench.sv
